/* sv/gbts_pkg.sv */
package gbts_pkg;

   // store geometry
   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = 13;
   localparam int DELTA_W  = 14;

   typedef logic [2:0]                req_code_type;
   typedef logic [7:0]                byte_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic [1:0]                status_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   localparam pos_type CAP_POS = POS_W'(CAPACITY);

   // request codes
   localparam req_code_type REQ_INSERT   = 3'd0;
   localparam req_code_type REQ_DELETE   = 3'd1;
   localparam req_code_type REQ_MOVE_REL = 3'd2;
   localparam req_code_type REQ_MOVE_ABS = 3'd3;
   localparam req_code_type REQ_READ     = 3'd4;

   // status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   // memory port bundles
   typedef struct packed {
      logic     en;
      addr_type addr;
      byte_type data;
   } ram_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } ram_rd_type;

endpackage

/* sv/gbts_if.sv */
interface gbts_req_if;
   logic                  valid;
   logic                  ready;
   gbts_pkg::req_code_type req_type;
   gbts_pkg::byte_type     char_in;
   gbts_pkg::delta_type    move_delta;
   gbts_pkg::pos_type      position;

   modport source (output valid, output req_type, output char_in, output move_delta,
                   output position, input ready);
   modport sink   (input valid, input req_type, input char_in, input move_delta,
                   input position, output ready);
endinterface

interface gbts_rsp_if;
   logic                valid;
   logic                ready;
   gbts_pkg::pos_type    cursor_position;
   gbts_pkg::pos_type    text_length;
   gbts_pkg::byte_type   read_byte;
   gbts_pkg::status_type status;

   modport source (output valid, output cursor_position, output text_length,
                   output read_byte, output status, input ready);
   modport sink   (input valid, input cursor_position, input text_length,
                   input read_byte, input status, output ready);
endinterface

/* sv/gbts_ram.sv */
module gbts_ram (
   input  logic                 clock,
   input  gbts_pkg::ram_wr_type wr,
   input  gbts_pkg::ram_rd_type rd,
   output gbts_pkg::byte_type   rd_data
);
   import gbts_pkg::*;

   byte_type mem [CAPACITY];
   byte_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gbts_ctrl.sv */
module gbts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   gbts_req_if.sink             req_ch,
   gbts_rsp_if.source           rsp_ch,
   output gbts_pkg::ram_wr_type ram_wr,
   output gbts_pkg::ram_rd_type ram_rd,
   input  gbts_pkg::byte_type   ram_rd_data
);
   import gbts_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_MOVE    = 2'd1;
   localparam logic [1:0] S_RD_WAIT = 2'd2;
   localparam logic [1:0] S_DONE    = 2'd3;

   logic [1:0] state_ff, state_in;
   pos_type    gb_ff, gb_in;
   pos_type    gf_ff, gf_in;
   pos_type    cnt_ff, cnt_in;
   addr_type   rd_addr_ff, rd_addr_in;
   logic       left_ff, left_in;
   logic       wr_pend_ff, wr_pend_in;
   byte_type   rbyte_ff, rbyte_in;

   logic       rsp_valid_ff, rsp_valid_in;
   pos_type    cursor_ff, cursor_in;
   pos_type    length_ff, length_in;
   byte_type   rbyte_out_ff, rbyte_out_in;
   status_type status_ff, status_in;

   logic       out_free;
   logic       accept;
   logic       load;
   byte_type   ld_byte;
   status_type ld_status;

   logic [DELTA_W-1:0] delta_u;
   logic [DELTA_W-1:0] mv_mag;
   logic               mv_left;
   pos_type            avail;
   pos_type            limit;
   pos_type            mv_cnt;
   pos_type            cur_len;
   logic               rd_in_range;
   addr_type           rd_idx;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE) && out_free;
   assign accept        = req_ch.valid && req_ch.ready;

   // move distance, clamped to the text ends
   always_comb begin
      delta_u = req_ch.move_delta;
      if (req_ch.req_type == REQ_MOVE_ABS) begin
         mv_left = req_ch.position < gb_ff;
         mv_mag  = mv_left ? {1'b0, gb_ff - req_ch.position}
                           : {1'b0, req_ch.position - gb_ff};
      end else begin
         mv_left = delta_u[DELTA_W-1];
         mv_mag  = mv_left ? (~delta_u + 1'b1) : delta_u;
      end
      avail  = CAP_POS - gf_ff;
      limit  = mv_left ? gb_ff : avail;
      mv_cnt = (mv_mag < {1'b0, limit}) ? mv_mag[POS_W-1:0] : limit;
   end

   // logical read index to physical address
   always_comb begin
      cur_len     = CAP_POS - gf_ff + gb_ff;
      rd_in_range = req_ch.position < cur_len;
      rd_idx      = (req_ch.position < gb_ff) ? req_ch.position[ADDR_W-1:0]
                    : ADDR_W'(gf_ff + (req_ch.position - gb_ff));
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      gb_in      = gb_ff;
      gf_in      = gf_ff;
      cnt_in     = cnt_ff;
      rd_addr_in = rd_addr_ff;
      left_in    = left_ff;
      wr_pend_in = 1'b0;
      rbyte_in   = rbyte_ff;
      ram_wr     = '0;
      ram_rd     = '0;
      load       = 1'b0;
      ld_byte    = '0;
      ld_status  = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.req_type)
                  REQ_INSERT: begin
                     load = 1'b1;
                     if (gb_ff == gf_ff) begin
                        ld_status = ST_FULL;
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = gb_ff[ADDR_W-1:0];
                        ram_wr.data = req_ch.char_in;
                        gb_in       = gb_ff + 1'b1;
                     end
                  end
                  REQ_DELETE: begin
                     load = 1'b1;
                     if (gb_ff != '0) begin
                        gb_in = gb_ff - 1'b1;
                     end
                  end
                  REQ_MOVE_REL, REQ_MOVE_ABS: begin
                     if (mv_cnt == '0) begin
                        load = 1'b1;
                     end else begin
                        state_in   = S_MOVE;
                        cnt_in     = mv_cnt;
                        left_in    = mv_left;
                        rd_addr_in = mv_left ? ADDR_W'(gb_ff - 1'b1) : gf_ff[ADDR_W-1:0];
                     end
                  end
                  REQ_READ: begin
                     if (rd_in_range) begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = rd_idx;
                        state_in    = S_RD_WAIT;
                     end else begin
                        load      = 1'b1;
                        ld_status = ST_RANGE;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // read side: one byte fetched per cycle
            if (cnt_ff != '0) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = rd_addr_ff;
               cnt_in      = cnt_ff - 1'b1;
               rd_addr_in  = left_ff ? rd_addr_ff - 1'b1 : rd_addr_ff + 1'b1;
               wr_pend_in  = 1'b1;
            end
            // write side: byte fetched last cycle lands across the gap
            if (wr_pend_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.data = ram_rd_data;
               if (left_ff) begin
                  ram_wr.addr = ADDR_W'(gf_ff - 1'b1);
                  gb_in       = gb_ff - 1'b1;
                  gf_in       = gf_ff - 1'b1;
               end else begin
                  ram_wr.addr = gb_ff[ADDR_W-1:0];
                  gb_in       = gb_ff + 1'b1;
                  gf_in       = gf_ff + 1'b1;
               end
            end
            if (cnt_ff == '0 && !wr_pend_ff) begin
               state_in = S_DONE;
               rbyte_in = '0;
            end
         end
         S_RD_WAIT: begin
            rbyte_in = ram_rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               ld_byte  = rbyte_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cursor_in    = cursor_ff;
      length_in    = length_ff;
      rbyte_out_in = rbyte_out_ff;
      status_in    = status_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         cursor_in    = gb_in;
         length_in    = CAP_POS - gf_in + gb_in;
         rbyte_out_in = ld_byte;
         status_in    = ld_status;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gb_ff        <= '0;
         gf_ff        <= CAP_POS;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gb_ff        <= gb_in;
         gf_ff        <= gf_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rd_addr_ff   <= rd_addr_in;
      left_ff      <= left_in;
      rbyte_ff     <= rbyte_in;
      cursor_ff    <= cursor_in;
      length_ff    <= length_in;
      rbyte_out_ff <= rbyte_out_in;
      status_ff    <= status_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.cursor_position = cursor_ff;
   assign rsp_ch.text_length     = length_ff;
   assign rsp_ch.read_byte       = rbyte_out_ff;
   assign rsp_ch.status          = status_ff;

endmodule

/* sv/gap_buffer_text_store_top.sv */
// Gap-buffer text store: 4096-byte memory plus gap start/end registers.
// Insert, delete, no-op moves, out-of-range reads: result in the cycle after acceptance.
// In-range read: one memory read, then the byte is staged into the result register.
// Cursor move: one byte crosses the gap per cycle through the single read and single
// write port of the memory. One request is in flight at a time.
// Synchronous reset empties the text (cursor 0, length 0); memory contents are not cleared.
module gap_buffer_text_store_top (
   input  logic       clock,
   input  logic       reset,
   gbts_req_if.sink   req_ch,
   gbts_rsp_if.source rsp_ch
);
   import gbts_pkg::*;

   ram_wr_type ram_wr;
   ram_rd_type ram_rd;
   byte_type   ram_rd_data;

   // request sequencer and result register
   gbts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

   // text memory
   gbts_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

endmodule
